FILE: design/vsws_pkg.sv
// ---------------------------------------------------------------------------
// vsws_pkg
// Shared types and constants for the vital sign window statistics block.
// ---------------------------------------------------------------------------
package vsws_pkg;

   // Default window length in one-second samples
   localparam int WINDOW_DEFAULT = 60;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int MASK_W     = 4;
   localparam int PRESSURE_W = 9;
   localparam int TEMP_W     = 10;
   localparam int COUNT_W    = 9;
   localparam int CH_COUNT   = 4;

   // Largest temperature code that fits the sample field
   localparam int TEMP_MAX = (1 << TEMP_W) - 1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

   // Channel bit positions in the mask
   localparam int CH_PRESSURE    = 0;
   localparam int CH_TEMPERATURE = 1;
   localparam int CH_PULSE       = 2;
   localparam int CH_BREATH      = 3;

   // One window slot, all four channels side by side
   typedef struct packed {
      logic [PRESSURE_W-1:0] pressure;
      logic [TEMP_W-1:0]     temperature;
      logic                  pulse;
      logic                  breath;
   } entry_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_HOLD   = 4'b1000
   } state_type;

endpackage

FILE: design/vsws_ram.sv
// ---------------------------------------------------------------------------
// vsws_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ---------------------------------------------------------------------------
module vsws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/vsws_div.sv
// ---------------------------------------------------------------------------
// vsws_div
// Division by a fixed divisor through a reciprocal multiply; the quotient is
// registered and comes with done in the cycle after start.
// ---------------------------------------------------------------------------
module vsws_div #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR    = 60
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   // Reciprocal rounded up and scaled by 2^(DIVIDEND_W + clog2 DIVISOR), so the
   // truncated product equals the truncated quotient for every dividend
   localparam int     LOG_D   = $clog2(DIVISOR);
   localparam int     SHIFT   = DIVIDEND_W + LOG_D;
   localparam int     RECIP_W = DIVIDEND_W + 1;
   localparam int     PROD_W  = DIVIDEND_W + RECIP_W;
   localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) /
                                longint'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

   logic [PROD_W-1:0]     product;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic                  done_ff;

   // Multiply by the reciprocal and keep the bits above the scale
   assign product = {{RECIP_W{1'b0}}, dividend} * {{DIVIDEND_W{1'b0}}, RECIP_C};
   assign quo_in  = DIVIDEND_W'(product >> SHIFT);

   // Control: pulse done the cycle after start
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Datapath: capture the quotient on start
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/vital_sign_window_stats.sv
// ---------------------------------------------------------------------------
// vital_sign_window_stats
// Sliding windows over pressure, temperature, pulse and breath samples with
// max/min pressure, mean temperature and beat counts per sample tick.
// Sequence: an accepted sample tick starts a scan with one RAM read per slot,
//    then the temperature sum goes through the reciprocal divider and the
//    result is loaded into the output register from HOLD. One tick at a time;
//    requests stall until that load; start, stop and the spare code give no beat.
// Reset: all channels disabled, all windows empty, head at slot zero; the
//    RAM itself is not cleared, per-channel fill counters mark windows empty.
// ---------------------------------------------------------------------------
module vital_sign_window_stats #(
   parameter int WINDOW = vsws_pkg::WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [vsws_pkg::CMD_W-1:0]      req_command,
   input  logic [vsws_pkg::MASK_W-1:0]     req_channel_mask,
   input  logic [vsws_pkg::PRESSURE_W-1:0] req_pressure_sample,
   input  logic [vsws_pkg::TEMP_W-1:0]     req_temperature_sample,
   input  logic                            req_pulse_beat,
   input  logic                            req_breath_event,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [vsws_pkg::PRESSURE_W-1:0] rsp_systolic,
   output logic [vsws_pkg::PRESSURE_W-1:0] rsp_diastolic,
   output logic                            rsp_pressure_ready,
   output logic [vsws_pkg::TEMP_W-1:0]     rsp_mean_temperature,
   output logic                            rsp_temperature_ready,
   output logic [vsws_pkg::COUNT_W-1:0]    rsp_pulse_count,
   output logic                            rsp_pulse_ready,
   output logic [vsws_pkg::COUNT_W-1:0]    rsp_breath_count,
   output logic                            rsp_breath_ready
);

   localparam int IDX_W   = $clog2(WINDOW);
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int SUM_W   = $clog2(WINDOW * vsws_pkg::TEMP_MAX + 1);
   localparam int ENTRY_W = $bits(vsws_pkg::entry_type);
   localparam int CH_N    = vsws_pkg::CH_COUNT;
   localparam int P_W     = vsws_pkg::PRESSURE_W;
   localparam int T_W     = vsws_pkg::TEMP_W;
   localparam int C_W     = vsws_pkg::COUNT_W;

   vsws_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]  head_ff;
   logic [CH_N-1:0]   enabled_ff, enabled_in;
   logic [FILL_W-1:0] fill_ff [CH_N];
   logic [FILL_W-1:0] fill_in [CH_N];
   logic [CH_N-1:0]   ready_ff, ready_in;

   logic [IDX_W-1:0]  idx_ff;
   logic              issue_ff;
   logic              rd_valid_ff;
   logic              rd_last_ff;
   logic              div_start_ff;

   logic [P_W-1:0]    max_ff, max_in;
   logic [P_W-1:0]    min_ff, min_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [C_W-1:0]    pcnt_ff, pcnt_in;
   logic [C_W-1:0]    bcnt_ff, bcnt_in;

   logic              rsp_valid_ff;
   logic [P_W-1:0]    systolic_ff;
   logic [P_W-1:0]    diastolic_ff;
   logic [T_W-1:0]    mean_ff;
   logic [C_W-1:0]    pulse_cnt_ff;
   logic [C_W-1:0]    breath_cnt_ff;
   logic [CH_N-1:0]   rsp_ready_ff;

   logic              req_accept;
   logic              tick_accept;
   logic              start_accept;
   logic              stop_accept;
   logic              rsp_free;
   logic              rd_en;
   logic              div_done;
   logic [SUM_W-1:0]  div_quotient;

   vsws_pkg::entry_type wr_entry;
   vsws_pkg::entry_type rd_entry;
   logic [ENTRY_W-1:0]  rd_data;

   // Decode accepted request beats
   assign req_stall    = (state_ff != vsws_pkg::ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign tick_accept  = req_accept && (req_command == vsws_pkg::CMD_TICK);
   assign start_accept = req_accept && (req_command == vsws_pkg::CMD_START);
   assign stop_accept  = req_accept && (req_command == vsws_pkg::CMD_STOP);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   // Window storage: one slot holds all four channels
   always_comb begin
      wr_entry.pressure    = req_pressure_sample;
      wr_entry.temperature = req_temperature_sample;
      wr_entry.pulse       = req_pulse_beat;
      wr_entry.breath      = req_breath_event;
   end

   assign rd_en    = (state_ff == vsws_pkg::ST_SCAN) && issue_ff;
   assign rd_entry = vsws_pkg::entry_type'(rd_data);

   vsws_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (tick_accept),
      .wr_addr (head_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Channel enables and fill counters; a window is full once WINDOW
   // consecutive enabled ticks have landed since the last stop
   always_comb begin
      enabled_in = enabled_ff;
      if (start_accept) begin
         enabled_in = enabled_ff | req_channel_mask;
      end else if (stop_accept) begin
         enabled_in = enabled_ff & ~req_channel_mask;
      end
      for (int ch = 0; ch < CH_N; ch++) begin
         fill_in[ch] = fill_ff[ch];
         if (tick_accept) begin
            if (!enabled_ff[ch]) begin
               fill_in[ch] = '0;
            end else if (fill_ff[ch] != FILL_W'(WINDOW)) begin
               fill_in[ch] = fill_ff[ch] + 1'b1;
            end
         end else if (stop_accept && req_channel_mask[ch]) begin
            fill_in[ch] = '0;
         end
         ready_in[ch] = (fill_in[ch] == FILL_W'(WINDOW));
      end
   end

   // Scan accumulation over the registered read data
   always_comb begin
      max_in  = (rd_entry.pressure > max_ff) ? rd_entry.pressure : max_ff;
      min_in  = (rd_entry.pressure < min_ff) ? rd_entry.pressure : min_ff;
      sum_in  = sum_ff + SUM_W'(rd_entry.temperature);
      pcnt_in = pcnt_ff + C_W'(rd_entry.pulse);
      bcnt_in = bcnt_ff + C_W'(rd_entry.breath);
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vsws_pkg::ST_IDLE: begin
            if (tick_accept) begin
               state_in = vsws_pkg::ST_SCAN;
            end
         end
         vsws_pkg::ST_SCAN: begin
            if (rd_valid_ff && rd_last_ff) begin
               state_in = vsws_pkg::ST_DIVIDE;
            end
         end
         vsws_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = vsws_pkg::ST_HOLD;
            end
         end
         vsws_pkg::ST_HOLD: begin
            if (rsp_free) begin
               state_in = vsws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vsws_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vsws_pkg::ST_IDLE;
         head_ff      <= '0;
         enabled_ff   <= '0;
         for (int ch = 0; ch < CH_N; ch++) begin
            fill_ff[ch] <= '0;
         end
         ready_ff     <= '0;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         for (int ch = 0; ch < CH_N; ch++) begin
            fill_ff[ch] <= fill_in[ch];
         end
         div_start_ff <= (state_ff == vsws_pkg::ST_SCAN) && rd_valid_ff && rd_last_ff;

         // Advance head and launch the scan on a tick
         if (tick_accept) begin
            ready_ff <= ready_in;
            head_ff  <= (head_ff == IDX_W'(WINDOW - 1)) ? '0 : head_ff + 1'b1;
            idx_ff   <= '0;
            issue_ff <= 1'b1;
         end else if (rd_en) begin
            if (idx_ff == IDX_W'(WINDOW - 1)) begin
               issue_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         rd_valid_ff <= rd_en;
         rd_last_ff  <= rd_en && (idx_ff == IDX_W'(WINDOW - 1));

         // Output register: load in HOLD, drop once taken
         if ((state_ff == vsws_pkg::ST_HOLD) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Accumulators
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         max_ff  <= '0;
         min_ff  <= '1;
         sum_ff  <= '0;
         pcnt_ff <= '0;
         bcnt_ff <= '0;
      end else if (rd_valid_ff) begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         sum_ff  <= sum_in;
         pcnt_ff <= pcnt_in;
         bcnt_ff <= bcnt_in;
      end
   end

   // Mean temperature: sum over the window divided by WINDOW
   vsws_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR    (WINDOW)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Result payload, zeroed for channels whose window is not full
   always_ff @(posedge clock) begin
      if ((state_ff == vsws_pkg::ST_HOLD) && rsp_free) begin
         systolic_ff   <= ready_ff[vsws_pkg::CH_PRESSURE]    ? max_ff : '0;
         diastolic_ff  <= ready_ff[vsws_pkg::CH_PRESSURE]    ? min_ff : '0;
         mean_ff       <= ready_ff[vsws_pkg::CH_TEMPERATURE] ? div_quotient[T_W-1:0] : '0;
         pulse_cnt_ff  <= ready_ff[vsws_pkg::CH_PULSE]       ? pcnt_ff : '0;
         breath_cnt_ff <= ready_ff[vsws_pkg::CH_BREATH]      ? bcnt_ff : '0;
         rsp_ready_ff  <= ready_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_systolic          = systolic_ff;
   assign rsp_diastolic         = diastolic_ff;
   assign rsp_pressure_ready    = rsp_ready_ff[vsws_pkg::CH_PRESSURE];
   assign rsp_mean_temperature  = mean_ff;
   assign rsp_temperature_ready = rsp_ready_ff[vsws_pkg::CH_TEMPERATURE];
   assign rsp_pulse_count       = pulse_cnt_ff;
   assign rsp_pulse_ready       = rsp_ready_ff[vsws_pkg::CH_PULSE];
   assign rsp_breath_count      = breath_cnt_ff;
   assign rsp_breath_ready      = rsp_ready_ff[vsws_pkg::CH_BREATH];

endmodule
